@@ rtl/rrp_pkg.sv @@
// Shared types and constants for the request parser.
`timescale 1ns / 1ps
package rrp_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    localparam logic [3:0]  DEC_BASE  = 4'd10;
    localparam logic [63:0] MUL_LIMIT = 64'd922337203685477580;
    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_OVF   = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] KIND_INT    = 2'd0;
    localparam logic [1:0] KIND_SIMPLE = 2'd1;
    localparam logic [1:0] KIND_BULK   = 2'd2;
    localparam logic [1:0] KIND_DOUBLE = 2'd3;

    typedef enum logic [1:0] {
        PUR_BULK  = 2'd0,
        PUR_COUNT = 2'd1,
        PUR_INT   = 2'd2
    } purpose_t;

    typedef enum logic [19:0] {
        PH_IDLE      = 20'h00001,
        PH_SKIP      = 20'h00002,
        PH_SS_TEXT   = 20'h00004,
        PH_SS_LF     = 20'h00008,
        PH_NUM_LEAD  = 20'h00010,
        PH_NUM_BODY  = 20'h00020,
        PH_NUM_LF    = 20'h00040,
        PH_BULK_DATA = 20'h00080,
        PH_BULK_CR   = 20'h00100,
        PH_BULK_LF   = 20'h00200,
        PH_ARG       = 20'h00400,
        PH_D_LEAD    = 20'h00800,
        PH_D_SIGN    = 20'h01000,
        PH_D_INT     = 20'h02000,
        PH_D_DOT0    = 20'h04000,
        PH_D_FRAC    = 20'h08000,
        PH_D_E       = 20'h10000,
        PH_D_ESIGN   = 20'h20000,
        PH_D_EXP     = 20'h40000,
        PH_D_LF      = 20'h80000
    } phase_t;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic [63:0] int_value;
        logic        token_end;
        logic        message_end;
        logic        parse_error;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
            || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

@@ rtl/rrp_parse_core.sv @@
// Parser state machine: one byte in, one result out, state updated per byte.
`timescale 1ns / 1ps
module rrp_parse_core #(
    parameter int COUNT_BITS = 63
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       c,
    output logic             res_any,
    output rrp_pkg::result_t res
);
    import rrp_pkg::*;

    localparam logic [63:0] COUNT_MAX = 64'(({{(COUNT_BITS){1'b1}}}));

    phase_t                phase_reg, phase_next;
    logic                  in_array_reg, in_array_next;
    logic [COUNT_BITS-1:0] args_left_reg, args_left_next;
    logic [COUNT_BITS-1:0] payload_left_reg, payload_left_next;
    logic [63:0]           magnitude_reg, magnitude_next;
    logic                  is_negative_reg, is_negative_next;
    logic                  digit_seen_reg, digit_seen_next;
    purpose_t              purpose_reg, purpose_next;

    logic [63:0]           mag_dig;
    logic [67:0]           mag_mul;
    logic                  bad_num;
    logic [COUNT_BITS-1:0] args_dec;
    logic                  exp_char;
    logic                  sign_char;
    logic                  dig;

    always_comb
    begin
        mag_mul = {4'b0, magnitude_reg} * {64'b0, DEC_BASE} + {60'b0, c[3:0] - CH_ZERO[3:0]};
        if (magnitude_reg > MUL_LIMIT || mag_mul[63:0] > NEG_LIMIT)
            mag_dig = MAG_OVF;
        else
            mag_dig = mag_mul[63:0];
        bad_num = !digit_seen_reg
            || magnitude_reg > (is_negative_reg ? NEG_LIMIT : POS_LIMIT);
        if (purpose_reg != PUR_INT)
            bad_num = bad_num || (is_negative_reg && magnitude_reg != 64'd0)
                || magnitude_reg > COUNT_MAX;
        args_dec  = args_left_reg - COUNT_BITS'(1);
        exp_char  = (c == CH_E_UP) || (c == CH_E_LO);
        sign_char = (c == CH_PLUS) || (c == CH_MINUS);
        dig       = is_digit(c);
    end

    always_comb
    begin
        phase_t dn;
        logic   dok;
        phase_next        = phase_reg;
        in_array_next     = in_array_reg;
        args_left_next    = args_left_reg;
        payload_left_next = payload_left_reg;
        magnitude_next    = magnitude_reg;
        is_negative_next  = is_negative_reg;
        digit_seen_next   = digit_seen_reg;
        purpose_next      = purpose_reg;
        res               = '0;
        dn                = PH_SKIP;
        dok               = 1'b1;

        // Frame start / error restart share one decoder; flags set by cases.
        begin : body
            logic restart, finish;
            logic [1:0] fkind;
            restart = 1'b0;
            finish  = 1'b0;
            fkind   = KIND_INT;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (!(c == CH_PLUS || c == CH_DOLLAR || c == CH_STAR))
                        res.parse_error = 1'b1;
                    restart = 1'b1;
                end
                PH_SKIP: restart = 1'b1;
                PH_SS_TEXT:
                begin
                    if (c == CH_CR)
                        phase_next = PH_SS_LF;
                    else
                    begin
                        res.token_kind = KIND_SIMPLE;
                        res.data_byte  = c;
                        res.data_valid = 1'b1;
                    end
                end
                PH_SS_LF:
                begin
                    if (c == CH_LF) begin finish = 1'b1; fkind = KIND_SIMPLE; end
                    else begin res.parse_error = 1'b1; restart = 1'b1; end
                end
                PH_NUM_LEAD:
                begin
                    if (is_ws(c))
                        phase_next = PH_NUM_LEAD;
                    else if (sign_char)
                    begin
                        is_negative_next = (c == CH_MINUS);
                        phase_next = PH_NUM_BODY;
                    end
                    else if (dig)
                    begin
                        magnitude_next  = mag_dig;
                        digit_seen_next = 1'b1;
                        phase_next = PH_NUM_BODY;
                    end
                    else begin res.parse_error = 1'b1; restart = 1'b1; end
                end
                PH_NUM_BODY:
                begin
                    if (dig)
                    begin
                        magnitude_next  = mag_dig;
                        digit_seen_next = 1'b1;
                    end
                    else if (bad_num || c != CH_CR)
                    begin
                        res.parse_error = 1'b1;
                        restart = 1'b1;
                    end
                    else
                        phase_next = PH_NUM_LF;
                end
                PH_NUM_LF:
                begin
                    if (c != CH_LF)
                    begin
                        res.parse_error = 1'b1;
                        restart = 1'b1;
                    end
                    else if (purpose_reg == PUR_INT)
                    begin
                        res.int_value = is_negative_reg ? (64'd0 - magnitude_reg)
                                                        : magnitude_reg;
                        finish = 1'b1;
                        fkind  = KIND_INT;
                    end
                    else if (purpose_reg == PUR_COUNT)
                    begin
                        args_left_next = magnitude_reg[COUNT_BITS-1:0];
                        if (magnitude_reg[COUNT_BITS-1:0] == '0)
                        begin
                            in_array_next   = 1'b0;
                            res.message_end = 1'b1;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            in_array_next = 1'b1;
                            phase_next    = PH_ARG;
                        end
                    end
                    else
                    begin
                        payload_left_next = magnitude_reg[COUNT_BITS-1:0];
                        phase_next = (magnitude_reg[COUNT_BITS-1:0] != '0) ? PH_BULK_DATA
                                                                         : PH_BULK_CR;
                    end
                end
                PH_BULK_DATA:
                begin
                    res.token_kind = KIND_BULK;
                    res.data_byte  = c;
                    res.data_valid = 1'b1;
                    payload_left_next = payload_left_reg - COUNT_BITS'(1);
                    if (payload_left_reg == COUNT_BITS'(1))
                        phase_next = PH_BULK_CR;
                end
                PH_BULK_CR:
                begin
                    if (c == CH_CR) phase_next = PH_BULK_LF;
                    else begin res.parse_error = 1'b1; restart = 1'b1; end
                end
                PH_BULK_LF:
                begin
                    if (c == CH_LF) begin finish = 1'b1; fkind = KIND_BULK; end
                    else begin res.parse_error = 1'b1; restart = 1'b1; end
                end
                PH_ARG:
                begin
                    if (c == CH_COLON || c == CH_DOLLAR)
                    begin
                        purpose_next     = (c == CH_COLON) ? PUR_INT : PUR_BULK;
                        magnitude_next   = '0;
                        is_negative_next = 1'b0;
                        digit_seen_next  = 1'b0;
                        phase_next       = PH_NUM_LEAD;
                    end
                    else if (c == CH_PLUS)
                        phase_next = PH_SS_TEXT;
                    else if (c == CH_COMMA)
                        phase_next = PH_D_LEAD;
                    else begin res.parse_error = 1'b1; restart = 1'b1; end
                end
                PH_D_LF:
                begin
                    if (c == CH_LF) begin finish = 1'b1; fkind = KIND_DOUBLE; end
                    else begin res.parse_error = 1'b1; restart = 1'b1; end
                end
                PH_D_LEAD, PH_D_SIGN, PH_D_INT, PH_D_DOT0,
                PH_D_FRAC, PH_D_E, PH_D_ESIGN, PH_D_EXP:
                begin
                    priority if (phase_reg == PH_D_LEAD && is_ws(c))
                        dn = PH_D_LEAD;
                    else if ((phase_reg == PH_D_INT || phase_reg == PH_D_FRAC
                              || phase_reg == PH_D_EXP) && c == CH_CR)
                        dn = PH_D_LF;
                    else if ((phase_reg == PH_D_LEAD || phase_reg == PH_D_E) && sign_char)
                        dn = (phase_reg == PH_D_LEAD) ? PH_D_SIGN : PH_D_ESIGN;
                    else if (dig)
                    begin
                        if (phase_reg == PH_D_LEAD || phase_reg == PH_D_SIGN
                            || phase_reg == PH_D_INT)
                            dn = PH_D_INT;
                        else if (phase_reg == PH_D_DOT0 || phase_reg == PH_D_FRAC)
                            dn = PH_D_FRAC;
                        else
                            dn = PH_D_EXP;
                    end
                    else if (c == CH_DOT && (phase_reg == PH_D_LEAD
                             || phase_reg == PH_D_SIGN || phase_reg == PH_D_INT))
                        dn = (phase_reg == PH_D_INT) ? PH_D_FRAC : PH_D_DOT0;
                    else if (exp_char && (phase_reg == PH_D_INT || phase_reg == PH_D_FRAC))
                        dn = PH_D_E;
                    else
                        dok = 1'b0;
                    if (!dok)
                    begin
                        res.parse_error = 1'b1;
                        restart = 1'b1;
                    end
                    else
                    begin
                        phase_next = dn;
                        if (!(dn == PH_D_LF || (phase_reg == PH_D_LEAD && dn == PH_D_LEAD)))
                        begin
                            res.token_kind = KIND_DOUBLE;
                            res.data_byte  = c;
                            res.data_valid = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res.parse_error = 1'b1;
                    restart = 1'b1;
                end
            endcase

            if (finish)
            begin
                res.token_kind = fkind;
                res.token_end  = 1'b1;
                if (in_array_reg)
                begin
                    args_left_next = args_dec;
                    if (args_dec == '0)
                    begin
                        in_array_next   = 1'b0;
                        res.message_end = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                    else
                        phase_next = PH_ARG;
                end
                else
                begin
                    res.message_end = 1'b1;
                    phase_next      = PH_IDLE;
                end
            end

            if (restart)
            begin
                in_array_next  = 1'b0;
                args_left_next = '0;
                if (c == CH_PLUS)
                    phase_next = PH_SS_TEXT;
                else if (c == CH_DOLLAR || c == CH_STAR)
                begin
                    purpose_next     = (c == CH_STAR) ? PUR_COUNT : PUR_BULK;
                    magnitude_next   = '0;
                    is_negative_next = 1'b0;
                    digit_seen_next  = 1'b0;
                    phase_next       = PH_NUM_LEAD;
                end
                else
                    phase_next = PH_SKIP;
            end
        end
        res_any = res.data_valid | res.token_end | res.message_end | res.parse_error;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            in_array_reg     <= 1'b0;
            args_left_reg    <= '0;
            payload_left_reg <= '0;
            magnitude_reg    <= '0;
            is_negative_reg  <= 1'b0;
            digit_seen_reg   <= 1'b0;
            purpose_reg      <= PUR_BULK;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            in_array_reg     <= in_array_next;
            args_left_reg    <= args_left_next;
            payload_left_reg <= payload_left_next;
            magnitude_reg    <= magnitude_next;
            is_negative_reg  <= is_negative_next;
            digit_seen_reg   <= digit_seen_next;
            purpose_reg      <= purpose_next;
        end
    end

endmodule

@@ rtl/rrp_out_skid.sv @@
// Two-entry output buffer that decouples result delivery from byte intake.
`timescale 1ns / 1ps
module rrp_out_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rrp_pkg::result_t push_data,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output rrp_pkg::result_t out_data
);
    import rrp_pkg::*;

    result_t    slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg != 2'd2) || out_ready;

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

endmodule

@@ rtl/resp_request_parser_unit.sv @@
// Top level of the RESP2 request parser.
`timescale 1ns / 1ps
// Streaming parser for RESP2-style request frames. One byte is taken per
// cycle on s_axis; each byte goes through the one-pass parse state machine
// and, when it yields a payload byte, a token end, a message end or an
// error, one result beat is written to a two-entry output buffer. The
// buffer lets a byte be taken in the same cycle that a finished result
// still waits on m_axis, so a steady one byte per cycle holds as long as
// the sink takes results; s_axis_tready drops only when both buffer slots
// are full and the sink is stalled. Each result is registered in the buffer.
// COUNT_BITS sets the width of the length and argument counters; larger
// counts are flagged as errors.
module resp_request_parser_unit #(
    parameter int COUNT_BITS = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [7:0] data_byte, [8] data_valid,
                                        // [72:9] int_value, [73] token_end,
                                        // [74] message_end, [75] parse_error
    output logic [1:0]  m_axis_tuser    // [1:0] token_kind
);
    import rrp_pkg::*;

    logic    room;
    logic    step;
    logic    res_any;
    result_t res;
    result_t out_res;

    // Advance the parser on every accepted beat.
    assign s_axis_tready = room;
    assign step          = s_axis_tvalid && room;

    rrp_parse_core #(.COUNT_BITS(COUNT_BITS)) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .c       (s_axis_tdata),
        .res_any (res_any),
        .res     (res)
    );

    rrp_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_any),
        .push_data (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tuser = out_res.token_kind;
    assign m_axis_tdata = {4'b0, out_res.parse_error, out_res.message_end,
                           out_res.token_end, out_res.int_value,
                           out_res.data_valid, out_res.data_byte};

endmodule

@@ rtl/rrp_checker.sv @@
// Port-level checks for the request parser, bound to the top level.
`timescale 1ns / 1ps
module rrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    // Every result beat carries at least one flag.
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8] || m_axis_tdata[73]
                           || m_axis_tdata[74] || m_axis_tdata[75]))
        else $error("result beat without flags");

    // Payload byte is zero when no data is carried.
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("stray data byte");

    // Input is never stalled while the output side is idle.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind resp_request_parser_unit rrp_checker u_rrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the RESP2 request parser.
`timescale 1ns / 1ps
module tb_top;
    import rrp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    resp_request_parser_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Parser state mirror
    phase_t      pm_phase;
    logic        pm_in_array;
    logic [63:0] pm_args_left;
    logic [63:0] pm_payload_left;
    logic [63:0] pm_mag;
    logic        pm_neg;
    logic        pm_digit;
    purpose_t    pm_purpose;
    result_t     pm_res;

    logic [7:0]  byte_queue[$];
    result_t     expected_beats[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    int          idle_cycles;
    bit          stimulus_done;
    bit          beat_taken;

    localparam logic [63:0] COUNT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    function automatic bit ws_char(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C
            || c == 8'h0D;
    endfunction

    function automatic bit dig_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic void begin_number(input purpose_t p);
        pm_purpose = p;
        pm_mag = 0;
        pm_neg = 1'b0;
        pm_digit = 1'b0;
        pm_phase = PH_NUM_LEAD;
    endfunction

    function automatic void pass_byte(input logic [1:0] k, input logic [7:0] c);
        pm_res.token_kind = k;
        pm_res.data_byte = c;
        pm_res.data_valid = 1'b1;
    endfunction

    function automatic void open_frame(input logic [7:0] c);
        pm_in_array = 1'b0;
        pm_args_left = 0;
        if (c == CH_PLUS)
            pm_phase = PH_SS_TEXT;
        else if (c == CH_DOLLAR)
            begin_number(PUR_BULK);
        else if (c == CH_STAR)
            begin_number(PUR_COUNT);
        else
            pm_phase = PH_SKIP;
    endfunction

    function automatic void flag_error(input logic [7:0] c);
        pm_res.parse_error = 1'b1;
        open_frame(c);
    endfunction

    function automatic void close_token(input logic [1:0] k);
        pm_res.token_kind = k;
        pm_res.token_end = 1'b1;
        if (pm_in_array)
        begin
            pm_args_left = (pm_args_left - 1) & COUNT_MAX;
            if (pm_args_left == 0)
            begin
                pm_in_array = 1'b0;
                pm_res.message_end = 1'b1;
                pm_phase = PH_IDLE;
            end
            else
                pm_phase = PH_ARG;
        end
        else
        begin
            pm_res.message_end = 1'b1;
            pm_phase = PH_IDLE;
        end
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        pm_digit = 1'b1;
        if (pm_mag > 64'd922337203685477580)
            pm_mag = '1;
        else
        begin
            pm_mag = pm_mag * 10 + 64'(c - 8'h30);
            if (pm_mag > 64'h8000_0000_0000_0000)
                pm_mag = '1;
        end
    endfunction

    function automatic void end_digits(input logic [7:0] c);
        logic [63:0] lim;
        bit bad;
        lim = pm_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        bad = !pm_digit || pm_mag > lim;
        if (pm_purpose != PUR_INT)
        begin
            if (pm_neg && pm_mag != 0)
                bad = 1;
            if (pm_mag > COUNT_MAX)
                bad = 1;
        end
        if (bad || c != CH_CR)
            flag_error(c);
        else
            pm_phase = PH_NUM_LF;
    endfunction

    function automatic void finish_number();
        if (pm_purpose == PUR_INT)
        begin
            pm_res.int_value = pm_neg ? (64'd0 - pm_mag) : pm_mag;
            close_token(KIND_INT);
        end
        else if (pm_purpose == PUR_COUNT)
        begin
            pm_args_left = pm_mag & COUNT_MAX;
            if (pm_args_left == 0)
            begin
                pm_in_array = 1'b0;
                pm_res.message_end = 1'b1;
                pm_phase = PH_IDLE;
            end
            else
            begin
                pm_in_array = 1'b1;
                pm_phase = PH_ARG;
            end
        end
        else
        begin
            pm_payload_left = pm_mag & COUNT_MAX;
            pm_phase = (pm_payload_left != 0) ? PH_BULK_DATA : PH_BULK_CR;
        end
    endfunction

    // Double text: walk the decimal grammar; a CR hands over to the LF check.
    function automatic void double_char(input logic [7:0] c);
        bit ex;
        bit sg;
        bit ok;
        bit to_lf;
        phase_t nxt;
        ex = (c == CH_E_UP || c == CH_E_LO);
        sg = (c == CH_PLUS || c == CH_MINUS);
        ok = 1;
        to_lf = 0;
        nxt = PH_SKIP;
        case (pm_phase)
            PH_D_LEAD:
            begin
                if (ws_char(c)) return;
                if (sg) nxt = PH_D_SIGN;
                else if (dig_char(c)) nxt = PH_D_INT;
                else if (c == CH_DOT) nxt = PH_D_DOT0;
                else ok = 0;
            end
            PH_D_SIGN:
            begin
                if (dig_char(c)) nxt = PH_D_INT;
                else if (c == CH_DOT) nxt = PH_D_DOT0;
                else ok = 0;
            end
            PH_D_INT:
            begin
                if (dig_char(c)) nxt = PH_D_INT;
                else if (c == CH_DOT) nxt = PH_D_FRAC;
                else if (ex) nxt = PH_D_E;
                else if (c == CH_CR) to_lf = 1;
                else ok = 0;
            end
            PH_D_DOT0:
            begin
                if (dig_char(c)) nxt = PH_D_FRAC;
                else ok = 0;
            end
            PH_D_FRAC:
            begin
                if (dig_char(c)) nxt = PH_D_FRAC;
                else if (ex) nxt = PH_D_E;
                else if (c == CH_CR) to_lf = 1;
                else ok = 0;
            end
            PH_D_E:
            begin
                if (sg) nxt = PH_D_ESIGN;
                else if (dig_char(c)) nxt = PH_D_EXP;
                else ok = 0;
            end
            PH_D_ESIGN:
            begin
                if (dig_char(c)) nxt = PH_D_EXP;
                else ok = 0;
            end
            default:
            begin
                if (dig_char(c)) nxt = PH_D_EXP;
                else if (c == CH_CR) to_lf = 1;
                else ok = 0;
            end
        endcase
        if (to_lf)
            pm_phase = PH_D_LF;
        else if (!ok)
            flag_error(c);
        else
        begin
            pass_byte(KIND_DOUBLE, c);
            pm_phase = nxt;
        end
    endfunction

    // Advance the mirror by one byte; return 1 when a result beat is due.
    function automatic bit parse_byte(input logic [7:0] c, output result_t r);
        pm_res = '0;
        case (pm_phase)
            PH_SKIP: open_frame(c);
            PH_SS_TEXT:
                if (c == CH_CR) pm_phase = PH_SS_LF;
                else pass_byte(KIND_SIMPLE, c);
            PH_SS_LF:
                if (c == CH_LF) close_token(KIND_SIMPLE);
                else flag_error(c);
            PH_NUM_LEAD:
                if (!ws_char(c))
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        pm_neg = (c == CH_MINUS);
                        pm_phase = PH_NUM_BODY;
                    end
                    else if (dig_char(c))
                    begin
                        take_digit(c);
                        pm_phase = PH_NUM_BODY;
                    end
                    else
                        flag_error(c);
                end
            PH_NUM_BODY:
                if (dig_char(c)) take_digit(c);
                else end_digits(c);
            PH_NUM_LF:
                if (c == CH_LF) finish_number();
                else flag_error(c);
            PH_BULK_DATA:
            begin
                pass_byte(KIND_BULK, c);
                pm_payload_left = (pm_payload_left - 1) & COUNT_MAX;
                if (pm_payload_left == 0) pm_phase = PH_BULK_CR;
            end
            PH_BULK_CR:
                if (c == CH_CR) pm_phase = PH_BULK_LF;
                else flag_error(c);
            PH_BULK_LF:
                if (c == CH_LF) close_token(KIND_BULK);
                else flag_error(c);
            PH_ARG:
                if (c == CH_COLON) begin_number(PUR_INT);
                else if (c == CH_PLUS) pm_phase = PH_SS_TEXT;
                else if (c == CH_DOLLAR) begin_number(PUR_BULK);
                else if (c == CH_COMMA) pm_phase = PH_D_LEAD;
                else flag_error(c);
            PH_D_LEAD, PH_D_SIGN, PH_D_INT, PH_D_DOT0, PH_D_FRAC, PH_D_E,
            PH_D_ESIGN, PH_D_EXP:
                double_char(c);
            PH_D_LF:
                if (c == CH_LF) close_token(KIND_DOUBLE);
                else flag_error(c);
            default:
                if (c == CH_PLUS || c == CH_DOLLAR || c == CH_STAR) open_frame(c);
                else flag_error(c);
        endcase
        r = pm_res;
        return pm_res.data_valid | pm_res.token_end | pm_res.message_end
            | pm_res.parse_error;
    endfunction

    // ---------------- stimulus builders ----------------
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_queue.push_back(s[i]);
    endtask

    function automatic string rand_digits(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(8'h30 + $urandom_range(9)))};
        return s;
    endfunction

    function automatic string rand_int_text();
        string s;
        int sel;
        sel = $urandom_range(9);
        s = "";
        if (sel == 0) s = " ";
        if ($urandom_range(2) == 0) s = {s, "-"};
        else if ($urandom_range(4) == 0) s = {s, "+"};
        if (sel == 1) return {s, "9223372036854775808"};
        if (sel == 2) return {s, rand_digits(20)};
        return {s, rand_digits($urandom_range(1, 5))};
    endfunction

    function automatic string rand_double_text();
        string s;
        s = ($urandom_range(3) == 0) ? "-" : "";
        if ($urandom_range(4) == 0) s = {" ", s};
        s = {s, rand_digits($urandom_range(1, 3))};
        if ($urandom_range(1)) s = {s, ".", rand_digits($urandom_range(1, 3))};
        if ($urandom_range(3) == 0)
            s = {s, $urandom_range(1) ? "e" : "E", $urandom_range(1) ? "-" : "",
                 rand_digits($urandom_range(1, 2))};
        return s;
    endfunction

    function automatic string rand_payload(input int n, input bit any_byte);
        string s;
        logic [7:0] b;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            b = any_byte ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
            if (b == 8'h00) b = 8'h01;
            s = {s, string'(b)};
        end
        return s;
    endfunction

    function automatic string rand_bulk();
        int n;
        n = $urandom_range(0, 6);
        return $sformatf("$%0d\r\n%s\r\n", n, rand_payload(n, 1));
    endfunction

    function automatic string rand_arg();
        case ($urandom_range(3))
            0: return {":", rand_int_text(), "\r\n"};
            1: return {"+", rand_payload($urandom_range(0, 4), 0), "\r\n"};
            2: return rand_bulk();
            default: return {",", rand_double_text(), "\r\n"};
        endcase
    endfunction

    function automatic string rand_frame();
        string s;
        int n;
        case ($urandom_range(3))
            0: return {"+", rand_payload($urandom_range(0, 5), 0), "\r\n"};
            1: return rand_bulk();
            default:
            begin
                n = $urandom_range(0, 4);
                s = $sformatf("*%0d\r\n", n);
                for (int i = 0; i < n; i++)
                    s = {s, rand_arg()};
                return s;
            end
        endcase
    endfunction

    // Corrupt a frame now and then: overwrite, drop or inject one byte.
    function automatic string mangle(input string s);
        int p;
        if (s.len() == 0) return s;
        p = $urandom_range(s.len() - 1);
        case ($urandom_range(2))
            0: s[p] = 8'($urandom_range(255)) | 8'h01;
            1: s = {s.substr(0, p - 1), s.substr(p + 1, s.len() - 1)};
            default: s = {s.substr(0, p), rand_payload(1, 1), s.substr(p + 1, s.len() - 1)};
        endcase
        return s;
    endfunction

    task automatic wait_drained();
        while (byte_queue.size() != 0 || expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [79:0] got,
                                   input logic [79:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // ---------------- driver ----------------
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || beat_taken)
        begin
            // the current beat (if any) was taken at the last rising edge
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= byte_queue[0];
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Pop a byte and predict exactly at its acceptance edge.
    always @(posedge clk)
    begin
        result_t r;
        beat_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            void'(byte_queue.pop_front());
            if (parse_byte(s_axis_tdata, r))
                expected_beats.push_back(r);
        end
    end

    // ---------------- receiver ----------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.token_kind  = m_axis_tuser;
            got.data_byte   = m_axis_tdata[7:0];
            got.data_valid  = m_axis_tdata[8];
            got.int_value   = m_axis_tdata[72:9];
            got.token_end   = m_axis_tdata[73];
            got.message_end = m_axis_tdata[74];
            got.parse_error = m_axis_tdata[75];
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat", 80'(got), '0);
            else
            begin
                want = expected_beats.pop_front();
                if (got.token_kind != want.token_kind)
                    report_mismatch("token_kind", 80'(got.token_kind), 80'(want.token_kind));
                if (got.data_byte != want.data_byte)
                    report_mismatch("data_byte", 80'(got.data_byte), 80'(want.data_byte));
                if (got.data_valid != want.data_valid)
                    report_mismatch("data_valid", 80'(got.data_valid), 80'(want.data_valid));
                if (got.int_value != want.int_value)
                    report_mismatch("int_value", 80'(got.int_value), 80'(want.int_value));
                if (got.token_end != want.token_end)
                    report_mismatch("token_end", 80'(got.token_end), 80'(want.token_end));
                if (got.message_end != want.message_end)
                    report_mismatch("message_end", 80'(got.message_end),
                                    80'(want.message_end));
                if (got.parse_error != want.parse_error)
                    report_mismatch("parse_error", 80'(got.parse_error),
                                    80'(want.parse_error));
            end
        end
    end

    // Watchdog: count cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || stimulus_done)
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL resp_request_parser_unit");
                $finish;
            end
        end
    end

    task automatic run_phase(input int n_bytes, input int sp, input int rp);
        send_idle_pct = sp;
        recv_stall_pct = rp;
        while (n_bytes > 0)
        begin
            string f;
            f = rand_frame();
            if ($urandom_range(9) == 0) f = mangle(f);
            else if ($urandom_range(29) == 0) f = {rand_payload(2, 1), f};
            push_text(f);
            n_bytes -= f.len();
            while (byte_queue.size() > 40)
                @(posedge clk);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        idle_cycles = 0;
        stimulus_done = 0;
        pm_phase = PH_IDLE;
        pm_in_array = 0;
        pm_args_left = 0;
        pm_payload_left = 0;
        pm_mag = 0;
        pm_neg = 0;
        pm_digit = 0;
        pm_purpose = PUR_BULK;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: junk, frame kinds, integer extremes, overflow, bad lengths,
        // empty array, nested star, double forms, unknown argument type.
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h00);
        push_text("+ok\r\n");
        push_text("$0\r\n\r\n*0\r\n");
        push_text("*3\r\n:-9223372036854775808\r\n:9223372036854775807\r\n:+0\r\n");
        push_text("*1\r\n:9223372036854775808\r\n");
        push_text("$-1\r\n$-0\r\n\r\n$9223372036854775808\r\n");
        push_text("*2\r\n,-1.5e+3\r\n,.5\r\n*1\r\n,inf\r\n*2\r\n*1\r\n?");
        push_text("*1\r\n$3\r\na\r\n\r\n$\t+\r\n");
        wait_drained();

        // Fill: hold the receiver off while bytes keep coming.
        hold_off_cycles = 300;
        push_text("*4\r\n+abcdefgh\r\n$8\r\n12345678\r\n,1e9\r\n:42\r\n");
        wait_drained();

        run_phase(300, 0, 0);
        run_phase(200, 84, 0);
        run_phase(200, 0, 84);
        run_phase(300, 23, 23);

        stimulus_done = 1;
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("PASS resp_request_parser_unit");
        else
            $display("FAIL resp_request_parser_unit");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rrp_pkg.sv
rtl/rrp_parse_core.sv
rtl/rrp_out_skid.sv
rtl/resp_request_parser_unit.sv
rtl/rrp_checker.sv
tb/tb_top.sv
